// ----- src/mf3_pkg.sv -----
package mf3_pkg;

   localparam int MAX_WIDTH_DEF   = 2048;
   localparam int MAX_HEIGHT_DEF  = 4096;
   localparam int WIDTH_REG_BITS  = 12;
   localparam int HEIGHT_REG_BITS = 13;
   localparam int CSR_DATA_BITS   = 13;
   localparam int CSR_INDEX_BITS  = 1;
   localparam int PIX_BITS        = 8;

   localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 12'd2048;
   localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 13'd4096;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   // input item codes
   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   // result queue: depth and the room kept free for items in flight
   localparam int OQ_DEPTH   = 16;
   localparam int OQ_RESERVE = 8;

   typedef logic [PIX_BITS-1:0] pix_type;
   typedef logic [8:0][PIX_BITS-1:0] win_type;

   typedef struct packed {
      logic is_drain;
      logic top_is_mid;
      logic emit_a;
      logic a_left1;
      logic emit_b;
      logic b_left2;
   } op_type;

   typedef struct packed {
      logic emit_a;
      logic emit_b;
      logic fend;
   } med_ctl_type;

   typedef struct packed {
      pix_type median_out;
      logic    frame_end;
      logic    last_of_step;
   } rsp_item_type;

   function automatic win_type cx(win_type v, int i, int j);
      win_type r;
      r = v;
      if (v[j] < v[i]) begin
         r[i] = v[j];
         r[j] = v[i];
      end
      return r;
   endfunction

   // gather three columns of the window into a 3x3 block
   function automatic win_type pick(win_type w, int lc, int cc, int rc);
      win_type v;
      for (int r = 0; r < 3; r++) begin
         v[r*3+0] = w[r*3+lc];
         v[r*3+1] = w[r*3+cc];
         v[r*3+2] = w[r*3+rc];
      end
      return v;
   endfunction

   // first three levels of the median-of-9 network
   function automatic win_type med9_front(win_type v);
      win_type t;
      t = v;
      t = cx(t, 1, 2); t = cx(t, 4, 5); t = cx(t, 7, 8);
      t = cx(t, 0, 1); t = cx(t, 3, 4); t = cx(t, 6, 7);
      t = cx(t, 1, 2); t = cx(t, 4, 5); t = cx(t, 7, 8);
      return t;
   endfunction

   // remaining ten exchanges, result in the center slot
   function automatic pix_type med9_back(win_type v);
      win_type t;
      t = v;
      t = cx(t, 0, 3); t = cx(t, 5, 8); t = cx(t, 4, 7);
      t = cx(t, 3, 6); t = cx(t, 1, 4); t = cx(t, 2, 5);
      t = cx(t, 4, 7); t = cx(t, 4, 2); t = cx(t, 6, 4);
      t = cx(t, 4, 2);
      return t[4];
   endfunction

endpackage

// ----- src/mf3_if.sv -----
interface mf3_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] pixel_in;
   modport source (output valid, command, pixel_in, input ready);
   modport sink (input valid, command, pixel_in, output ready);
endinterface

interface mf3_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] median_out;
   logic       frame_end;
   logic       last_of_step;
   modport source (output valid, median_out, frame_end, last_of_step, input ready);
   modport sink (input valid, median_out, frame_end, last_of_step, output ready);
endinterface

// ----- src/mf3_ram.sv -----
module mf3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ----- src/mf3_ctrl.sv -----
module mf3_ctrl #(
   parameter int MAX_WIDTH  = mf3_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = mf3_pkg::MAX_HEIGHT_DEF,
   parameter int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
   parameter int HW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [mf3_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [mf3_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  logic                                 accept,
   input  logic                                 command,
   output logic                                 act,
   output mf3_pkg::op_type                      op,
   output logic [AW-1:0]                        addr
);
   import mf3_pkg::*;

   logic [WIDTH_REG_BITS-1:0]  width_ff, width_in;
   logic [HEIGHT_REG_BITS-1:0] height_ff, height_in;
   logic [AW-1:0] col_ff, col_in;
   logic [HW-1:0] row_ff, row_in;
   logic          done_ff, done_in;
   logic [AW-1:0] w_m1;
   logic [HW-1:0] h_m1;
   logic          is_pixel, is_drain, at_row_end;

   // clamp the size registers into 1..max, kept as size minus one
   always_comb begin
      if (width_ff == '0) begin
         w_m1 = '0;
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         w_m1 = AW'(MAX_WIDTH - 1);
      end else begin
         w_m1 = AW'(width_ff - 12'd1);
      end
      if (height_ff == '0) begin
         h_m1 = '0;
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         h_m1 = HW'(MAX_HEIGHT - 1);
      end else begin
         h_m1 = HW'(height_ff - 13'd1);
      end
   end

   assign is_pixel   = (command == CMD_PIXEL) && !done_ff;
   assign is_drain   = (command == CMD_DRAIN) && done_ff;
   assign act        = accept && (is_pixel || is_drain);
   assign at_row_end = (col_ff >= w_m1);
   assign addr       = col_ff;

   always_comb begin
      op.is_drain   = is_drain;
      op.a_left1    = (col_ff == AW'(1));
      op.b_left2    = (col_ff == '0);
      if (is_drain) begin
         op.top_is_mid = (row_ff == '0);
         op.emit_a     = (col_ff != '0);
         op.emit_b     = at_row_end;
      end else begin
         op.top_is_mid = (row_ff == HW'(1));
         op.emit_a     = (row_ff != '0) && (col_ff != '0);
         op.emit_b     = (row_ff != '0) && at_row_end;
      end
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      done_in   = done_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_wdata[WIDTH_REG_BITS-1:0];
            CSR_IMAGE_HEIGHT: height_in = csr_wdata[HEIGHT_REG_BITS-1:0];
            default: ;
         endcase
      end
      if (act) begin
         if (!at_row_end) begin
            col_in = col_ff + AW'(1);
         end else if (is_drain) begin
            // frame complete: back to the start
            col_in  = '0;
            row_in  = '0;
            done_in = 1'b0;
         end else begin
            col_in = '0;
            if (row_ff >= h_m1) begin
               done_in = 1'b1;
            end else begin
               row_in = row_ff + HW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
         done_ff   <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         done_ff   <= done_in;
      end
   end

   a_drain_starts_at_zero: assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> (col_ff == '0))
      else $error("drain phase entered with nonzero column");

   a_act_needs_accept: assert property (@(posedge clock) disable iff (reset)
      act |-> (is_pixel != is_drain))
      else $error("item both pixel and drain");

   a_row_end_clears_col: assert property (@(posedge clock) disable iff (reset)
      (act && at_row_end) |=> (col_ff == '0))
      else $error("column not cleared at end of row");

endmodule

// ----- src/mf3_window.sv -----
module mf3_window #(
   parameter int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEF,
   parameter int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 act,
   input  mf3_pkg::op_type      op,
   input  logic [AW-1:0]        addr,
   input  mf3_pkg::pix_type     pixel,
   output logic                 med_valid,
   output mf3_pkg::med_ctl_type med_ctl,
   output mf3_pkg::win_type     win_a,
   output mf3_pkg::win_type     win_b
);
   import mf3_pkg::*;

   logic          s1_valid_ff, s1_fwd_ff;
   op_type        s1_op_ff;
   logic [AW-1:0] s1_addr_ff;
   pix_type       s1_px_ff;
   pix_type       fwd_prior_ff, fwd_older_ff;
   win_type       win_ff, win_in;
   logic          med_valid_ff, med_valid_in;
   med_ctl_type   med_ctl_ff, med_ctl_in;
   win_type       win_a_ff, win_a_in, win_b_ff, win_b_in;
   logic          fwd_in;
   pix_type       prior_rd, older_rd, mid, old, top, bot;
   logic          we;

   mf3_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_WIDTH), .AW(AW)) u_prior (
      .clock(clock), .we(we), .waddr(s1_addr_ff), .wdata(s1_px_ff),
      .re(act), .raddr(addr), .rdata(prior_rd)
   );

   mf3_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_WIDTH), .AW(AW)) u_older (
      .clock(clock), .we(we), .waddr(s1_addr_ff), .wdata(mid),
      .re(act), .raddr(addr), .rdata(older_rd)
   );

   // entry written this cycle is read by the item just accepted: take it from the bypass
   assign fwd_in = s1_valid_ff && !s1_op_ff.is_drain && (s1_addr_ff == addr);

   assign mid = s1_fwd_ff ? fwd_prior_ff : prior_rd;
   assign old = s1_fwd_ff ? fwd_older_ff : older_rd;
   assign top = s1_op_ff.top_is_mid ? mid : old;
   assign bot = s1_op_ff.is_drain ? mid : s1_px_ff;
   assign we  = s1_valid_ff && !s1_op_ff.is_drain;

   always_comb begin
      win_in = win_ff;
      for (int r = 0; r < 3; r++) begin
         win_in[r*3+0] = win_ff[r*3+1];
         win_in[r*3+1] = win_ff[r*3+2];
      end
      win_in[2] = top;
      win_in[5] = mid;
      win_in[8] = bot;
      med_valid_in      = s1_valid_ff && (s1_op_ff.emit_a || s1_op_ff.emit_b);
      med_ctl_in.emit_a = s1_op_ff.emit_a;
      med_ctl_in.emit_b = s1_op_ff.emit_b;
      med_ctl_in.fend   = s1_op_ff.is_drain && s1_op_ff.emit_b;
      win_a_in = pick(win_in, s1_op_ff.a_left1 ? 1 : 0, 1, 2);
      win_b_in = pick(win_in, s1_op_ff.b_left2 ? 2 : 1, 2, 2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s1_fwd_ff    <= 1'b0;
         win_ff       <= '0;
         med_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= act;
         s1_fwd_ff    <= act && fwd_in;
         if (s1_valid_ff) begin
            win_ff <= win_in;
         end
         med_valid_ff <= med_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (act) begin
         s1_op_ff   <= op;
         s1_addr_ff <= addr;
         s1_px_ff   <= pixel;
      end
      if (we) begin
         fwd_prior_ff <= s1_px_ff;
         fwd_older_ff <= mid;
      end
      med_ctl_ff <= med_ctl_in;
      win_a_ff   <= win_a_in;
      win_b_ff   <= win_b_in;
   end

   assign med_valid = med_valid_ff;
   assign med_ctl   = med_ctl_ff;
   assign win_a     = win_a_ff;
   assign win_b     = win_b_ff;

   a_fwd_after_write: assert property (@(posedge clock) disable iff (reset)
      s1_fwd_ff |-> $past(s1_valid_ff && !s1_op_ff.is_drain))
      else $error("bypass taken without a store write in flight");

   a_fwd_same_entry: assert property (@(posedge clock) disable iff (reset)
      s1_fwd_ff |-> (s1_addr_ff == $past(s1_addr_ff)))
      else $error("bypass taken for a different entry");

   a_med_from_stage: assert property (@(posedge clock) disable iff (reset)
      med_valid_ff |-> $past(s1_valid_ff))
      else $error("median request without a window update");

endmodule

// ----- src/mf3_median.sv -----
module mf3_median (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  med_valid,
   input  mf3_pkg::med_ctl_type  med_ctl,
   input  mf3_pkg::win_type      win_a,
   input  mf3_pkg::win_type      win_b,
   output logic                  push_a,
   output logic                  push_b,
   output mf3_pkg::rsp_item_type item_a,
   output mf3_pkg::rsp_item_type item_b
);
   import mf3_pkg::*;

   logic        s3_valid_ff;
   med_ctl_type s3_ctl_ff;
   win_type     s3_a_ff, s3_a_in, s3_b_ff, s3_b_in;

   assign s3_a_in = med9_front(win_a);
   assign s3_b_in = med9_front(win_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= med_valid;
      end
   end

   always_ff @(posedge clock) begin
      s3_ctl_ff <= med_ctl;
      s3_a_ff   <= s3_a_in;
      s3_b_ff   <= s3_b_in;
   end

   assign push_a = s3_valid_ff && s3_ctl_ff.emit_a;
   assign push_b = s3_valid_ff && s3_ctl_ff.emit_b;

   always_comb begin
      item_a.median_out   = med9_back(s3_a_ff);
      item_a.frame_end    = 1'b0;
      item_a.last_of_step = !s3_ctl_ff.emit_b;
      item_b.median_out   = med9_back(s3_b_ff);
      item_b.frame_end    = s3_ctl_ff.fend;
      item_b.last_of_step = 1'b1;
   end
endmodule

// ----- src/mf3_outq.sv -----
module mf3_outq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_a,
   input  logic                  push_b,
   input  mf3_pkg::rsp_item_type item_a,
   input  mf3_pkg::rsp_item_type item_b,
   output logic                  space_ok,
   output logic                  out_valid,
   input  logic                  out_ready,
   output mf3_pkg::rsp_item_type out_item
);
   import mf3_pkg::*;

   localparam int PW = $clog2(OQ_DEPTH);
   localparam int CW = $clog2(OQ_DEPTH + 1);

   rsp_item_type mem_ff [OQ_DEPTH];
   logic [PW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [CW-1:0] count_ff, count_in;
   logic [1:0]    n_push;
   logic          pop;
   rsp_item_type  first;

   assign n_push = {1'b0, push_a} + {1'b0, push_b};
   assign pop    = out_valid && out_ready;
   assign first  = push_a ? item_a : item_b;

   always_comb begin
      wp_in    = wp_ff + PW'(n_push);
      rp_in    = rp_ff + PW'(pop);
      count_in = count_ff + CW'(n_push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         mem_ff[wp_ff] <= first;
      end
      if (push_a && push_b) begin
         mem_ff[wp_ff + PW'(1)] <= item_b;
      end
   end

   // keep room for every item still in the pipeline plus the one being taken
   assign space_ok  = (count_ff <= CW'(OQ_DEPTH - OQ_RESERVE));
   assign out_valid = (count_ff != '0);
   assign out_item  = mem_ff[rp_ff];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (32'(count_ff) + 32'(n_push) <= OQ_DEPTH))
      else $error("result queue overflow");

   a_fend_is_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_item.frame_end) |-> out_item.last_of_step)
      else $error("frame end on an item that is not last of its step");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (pop && n_push == 2'd0) |=> (count_ff == $past(count_ff) - CW'(1)))
      else $error("queue count out of step");

endmodule

// ----- src/median_filter_3x3_u8.sv -----
// Accepted items pass the window input and output registers and the median register.
// Throughput: one item per cycle while the queue has room; a row's last item gives
// two results, so the result side sets the pace at one result per cycle through a
// 16-entry queue. The line stores are single-port-write RAMs with registered reads.
// Reset (synchronous): counters, window and queue clear; size registers return
// to 2048 x 4096; line store contents are undefined until written.
module median_filter_3x3_u8 #(
   parameter int MAX_WIDTH  = mf3_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = mf3_pkg::MAX_HEIGHT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   mf3_req_if.sink                            req_chan,
   mf3_rsp_if.source                          rsp_chan,
   input  logic                               csr_we,
   input  logic [mf3_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mf3_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import mf3_pkg::*;

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int HW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   logic          space_ok, accept, act;
   op_type        op;
   logic [AW-1:0] addr;
   logic          med_valid;
   med_ctl_type   med_ctl;
   win_type       win_a, win_b;
   logic          push_a, push_b;
   rsp_item_type  item_a, item_b, out_item;
   logic          out_valid;

   assign req_chan.ready = space_ok;
   assign accept         = req_chan.valid && space_ok;

   mf3_ctrl #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .AW(AW), .HW(HW)) u_ctrl (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .accept(accept), .command(req_chan.command),
      .act(act), .op(op), .addr(addr)
   );

   mf3_window #(.MAX_WIDTH(MAX_WIDTH), .AW(AW)) u_window (
      .clock(clock), .reset(reset),
      .act(act), .op(op), .addr(addr), .pixel(req_chan.pixel_in),
      .med_valid(med_valid), .med_ctl(med_ctl), .win_a(win_a), .win_b(win_b)
   );

   mf3_median u_median (
      .clock(clock), .reset(reset),
      .med_valid(med_valid), .med_ctl(med_ctl), .win_a(win_a), .win_b(win_b),
      .push_a(push_a), .push_b(push_b), .item_a(item_a), .item_b(item_b)
   );

   mf3_outq u_outq (
      .clock(clock), .reset(reset),
      .push_a(push_a), .push_b(push_b), .item_a(item_a), .item_b(item_b),
      .space_ok(space_ok),
      .out_valid(out_valid), .out_ready(rsp_chan.ready), .out_item(out_item)
   );

   assign rsp_chan.valid        = out_valid;
   assign rsp_chan.median_out   = out_item.median_out;
   assign rsp_chan.frame_end    = out_item.frame_end;
   assign rsp_chan.last_of_step = out_item.last_of_step;
endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import mf3_pkg::*;

   localparam int unsigned QUIET_LIMIT = 2000;
   localparam int unsigned RANDOM_ITEMS = 1400;

   // Tracks the filter state, predicts the medians each item causes and holds them in order.
   class median_tracker;
      pix_type prior_row [MAX_WIDTH_DEF];
      pix_type older_row [MAX_WIDTH_DEF];
      pix_type win [9];
      int unsigned column_count;
      int unsigned row_count;
      int unsigned drain_count;
      bit frame_done;
      logic [WIDTH_REG_BITS-1:0] width_reg;
      logic [HEIGHT_REG_BITS-1:0] height_reg;
      rsp_item_type pending_medians [$];
      int unsigned mismatches;

      function new();
         foreach (prior_row[i]) begin
            prior_row[i] = '0;
            older_row[i] = '0;
         end
         foreach (win[i]) win[i] = '0;
         column_count = 0;
         row_count = 0;
         drain_count = 0;
         frame_done = 1'b0;
         width_reg = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         mismatches = 0;
      endfunction

      function int unsigned eff_width();
         if (width_reg == 0) return 1;
         return (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg;
      endfunction

      function int unsigned eff_height();
         if (height_reg == 0) return 1;
         return (height_reg > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : height_reg;
      endfunction

      function void write_size_reg(logic [CSR_INDEX_BITS-1:0] index,
                                   logic [CSR_DATA_BITS-1:0] value);
         if (index == CSR_IMAGE_WIDTH) begin
            width_reg = value[WIDTH_REG_BITS-1:0];
         end else if (index == CSR_IMAGE_HEIGHT) begin
            height_reg = value[HEIGHT_REG_BITS-1:0];
         end
      endfunction

      function void shift_column(pix_type top, pix_type mid, pix_type bot);
         pix_type col [3];
         col[0] = top;
         col[1] = mid;
         col[2] = bot;
         for (int r = 0; r < 3; r++) begin
            win[r*3]   = win[r*3+1];
            win[r*3+1] = win[r*3+2];
            win[r*3+2] = col[r];
         end
      endfunction

      // median of the 3x3 block built from window columns lc, cc, rc
      function void push_median(int lc, int cc, int rc, logic fend);
         pix_type v [$];
         rsp_item_type item;
         for (int r = 0; r < 3; r++) begin
            v.push_back(win[r*3+lc]);
            v.push_back(win[r*3+cc]);
            v.push_back(win[r*3+rc]);
         end
         v.sort();
         item.median_out = v[4];
         item.frame_end = fend;
         item.last_of_step = 1'b0;
         pending_medians.push_back(item);
      endfunction

      function void take_item(logic cmd, pix_type px);
         int unsigned w;
         int unsigned h;
         int unsigned c;
         int unsigned k;
         int n;
         pix_type mid;
         pix_type top;
         w = eff_width();
         h = eff_height();
         n = pending_medians.size();
         if (cmd == CMD_PIXEL) begin
            if (frame_done) return;
            c = column_count;
            mid = prior_row[c];
            top = (row_count == 1) ? mid : older_row[c];
            shift_column(top, mid, px);
            older_row[c] = mid;
            prior_row[c] = px;
            if (row_count >= 1) begin
               if (c >= 1) push_median((c == 1) ? 1 : 0, 1, 2, 1'b0);
               if (c >= w - 1) push_median((c == 0) ? 2 : 1, 2, 2, 1'b0);
            end
            if (c >= w - 1) begin
               column_count = 0;
               if (row_count >= h - 1) begin
                  frame_done = 1'b1;
                  drain_count = 0;
               end else begin
                  row_count++;
               end
            end else begin
               column_count = c + 1;
            end
         end else begin
            if (!frame_done) return;
            k = drain_count;
            mid = prior_row[k];
            top = (row_count >= 1) ? older_row[k] : mid;
            // bottom row clamps to the last input row
            shift_column(top, mid, mid);
            if (k >= 1) push_median((k == 1) ? 1 : 0, 1, 2, 1'b0);
            if (k >= w - 1) begin
               push_median((k == 0) ? 2 : 1, 2, 2, 1'b1);
               row_count = 0;
               column_count = 0;
               drain_count = 0;
               frame_done = 1'b0;
            end else begin
               drain_count = k + 1;
            end
         end
         if (pending_medians.size() > n) begin
            pending_medians[pending_medians.size()-1].last_of_step = 1'b1;
         end
      endfunction

      function void check_median(rsp_item_type got);
         rsp_item_type want;
         if (pending_medians.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected result: median %0d frame_end %0b last_of_step %0b",
                        got.median_out, got.frame_end, got.last_of_step);
            end
            return;
         end
         want = pending_medians.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display({"mismatch at %0t: median exp %0d got %0d, ",
                         "frame_end exp %0b got %0b, last_of_step exp %0b got %0b"},
                        $realtime, want.median_out, got.median_out, want.frame_end,
                        got.frame_end, want.last_of_step, got.last_of_step);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   mf3_req_if pixel_bus ();
   mf3_rsp_if median_bus ();

   median_tracker tracker;

   int unsigned burst_left = 0;
   int unsigned counted_items = 0;
   int unsigned quiet_cycles = 0;
   int pixel_style = 0;
   pix_type tone = '0;

   int stall_mode = 0;
   int unsigned mode_left = 0;
   int unsigned stall_left = 0;
   int unsigned stall_phase = 0;

   pix_type corner_values [9] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'hAA, 8'h55,
                                  8'h00};

   median_filter_3x3_u8 DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (pixel_bus),
      .rsp_chan  (median_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) tracker.write_size_reg(csr_index, csr_wdata);
         if (median_bus.valid && median_bus.ready) begin
            tracker.check_median({median_bus.median_out, median_bus.frame_end,
                                  median_bus.last_of_step});
         end
         if (pixel_bus.valid && pixel_bus.ready) begin
            tracker.take_item(pixel_bus.command, pixel_bus.pixel_in);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (pixel_bus.valid && pixel_bus.ready)
          || (median_bus.valid && median_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side: rotate between free flow, coin-flip, periodic and long stalls
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(3);
         mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      stall_phase++;
      case (stall_mode)
         0: median_bus.ready = 1'b1;
         1: median_bus.ready = 1'($urandom_range(1));
         2: median_bus.ready = (stall_phase % 3 == 0);
         default: begin
            if (stall_left > 0) begin
               stall_left--;
               median_bus.ready = 1'b0;
            end else begin
               median_bus.ready = 1'b1;
               if ($urandom_range(9) == 0) stall_left = $urandom_range(5, 20);
            end
         end
      endcase
   end

   function automatic pix_type next_pixel();
      case (pixel_style)
         0: return pix_type'($urandom);
         1: return $urandom_range(1) ? 8'hFF : 8'h00;
         2: return tone + pix_type'($urandom_range(4));
         default: return ($urandom_range(2) == 0) ? pix_type'($urandom) : tone;
      endcase
   endfunction

   // call at a falling edge; returns at the falling edge after the item is taken
   task automatic drive_item(logic cmd, pix_type px);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            pixel_bus.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 40);
      end
      pixel_bus.valid = 1'b1;
      pixel_bus.command = cmd;
      pixel_bus.pixel_in = px;
      @(posedge clock);
      while (!pixel_bus.ready) @(posedge clock);
      burst_left--;
      @(negedge clock);
   endtask

   // hold off items until every predicted median is out, then cover the pipeline
   task automatic settle();
      pixel_bus.valid = 1'b0;
      while (tracker.pending_medians.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_size(logic [CSR_INDEX_BITS-1:0] index, int unsigned value);
      csr_we = 1'b1;
      csr_index = index;
      csr_wdata = value[CSR_DATA_BITS-1:0];
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic write_sizes(int unsigned w, int unsigned h);
      csr_we = 1'b1;
      csr_index = CSR_IMAGE_WIDTH;
      csr_wdata = w[CSR_DATA_BITS-1:0];
      @(negedge clock);
      csr_index = CSR_IMAGE_HEIGHT;
      csr_wdata = h[CSR_DATA_BITS-1:0];
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // stream one frame to its final median, with stray items mixed in and an optional size write midway
   task automatic run_frame(int unsigned noise_pct, int unsigned split_after);
      int unsigned sent;
      bit was_done;
      bit finished;
      bit stray;
      logic cmd;
      sent = 0;
      finished = 1'b0;
      while (!finished) begin
         if (split_after > 0 && sent == split_after) begin
            settle();
            // width may only shrink here so no unwritten line entry is read
            if ($urandom_range(1)) write_size(CSR_IMAGE_WIDTH, $urandom_range(tracker.eff_width()));
            else write_size(CSR_IMAGE_HEIGHT, $urandom_range(8));
         end
         was_done = tracker.frame_done;
         stray = ($urandom_range(99) < noise_pct);
         if (was_done) cmd = stray ? CMD_PIXEL : CMD_DRAIN;
         else cmd = stray ? CMD_DRAIN : CMD_PIXEL;
         drive_item(cmd, next_pixel());
         if (!stray) begin
            sent++;
            counted_items++;
         end
         if (was_done && cmd == CMD_DRAIN && !tracker.frame_done) finished = 1'b1;
      end
   endtask

   initial begin
      tracker = new();
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_IMAGE_WIDTH;
      csr_wdata = '0;
      pixel_bus.valid = 1'b0;
      pixel_bus.command = CMD_PIXEL;
      pixel_bus.pixel_in = '0;
      median_bus.ready = 1'b0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // zero-sized registers act as a single pixel; stray items must be dropped
      write_sizes(0, 0);
      drive_item(CMD_DRAIN, 8'h5A);
      drive_item(CMD_PIXEL, 8'hFF);
      drive_item(CMD_PIXEL, 8'h00);
      drive_item(CMD_DRAIN, 8'h00);

      settle();
      write_sizes(3, 3);
      foreach (corner_values[i]) drive_item(CMD_PIXEL, corner_values[i]);
      repeat (3) drive_item(CMD_DRAIN, 8'hFF);

      settle();
      write_sizes(1, 3);
      drive_item(CMD_PIXEL, 8'h00);
      drive_item(CMD_PIXEL, 8'hFF);
      drive_item(CMD_PIXEL, 8'h80);
      drive_item(CMD_DRAIN, 8'h7F);

      // register values beyond the maximum act as the maximum; shrink to end the row
      settle();
      write_sizes(4095, 8191);
      pixel_style = 0;
      repeat (6) drive_item(CMD_PIXEL, next_pixel());
      settle();
      write_sizes(3, 2);
      run_frame(0, 0);

      counted_items = 0;
      while (counted_items < RANDOM_ITEMS) begin
         if ($urandom_range(9) < 6) begin
            settle();
            case ($urandom_range(9))
               0: write_sizes($urandom_range(0, 3), $urandom_range(0, 6));
               1, 2: write_sizes($urandom_range(9, 40), $urandom_range(0, 4));
               default: write_sizes($urandom_range(1, 8), $urandom_range(0, 6));
            endcase
         end
         pixel_style = $urandom_range(3);
         tone = pix_type'($urandom);
         run_frame(($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8),
                   ($urandom_range(3) == 0) ? $urandom_range(1, 30) : 0);
      end

      pixel_bus.valid = 1'b0;
      while (tracker.pending_medians.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (tracker.mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
